// File: hdl/iiea_pkg.sv
// shared types and constants for the indexed insert/erase array
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iiea_pkg;

  // storage depth of the list
  localparam int CAPACITY = 16;

  // field widths fixed by the item format
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;

  // width of the readout pointer into the entry chain
  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_DUMP   = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;       // run insert, erase, empty dump or unused code now
    logic dump_step;  // emit the entry at the readout pointer
  } iiea_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic dump_last;
  } iiea_sts_t;

endpackage

`default_nettype wire

// File: hdl/indexed_insert_erase_array.sv
// top level of the indexed insert/erase array
// depends on iiea_pkg, iiea_ctrl and iiea_dpath
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries held in a register
// chain. An item is taken when start is high and busy is low. Insert and
// erase move the whole chain at once: their single result shows on the
// result ports in the cycle after the item is taken, with done high, and the
// next item may be taken in that same cycle, so these run at one item per
// cycle. A dump of n entries keeps busy high while it walks the chain and
// reads one entry per cycle through the chain readout mux into the result
// registers once the state has moved to dump; n results, on consecutive
// cycles; the last one carries last. A dump of an empty list, and the unused
// function code, give one result like insert and erase. Results must be
// taken in the cycle they appear: there is no way to stall them.
module indexed_insert_erase_array import iiea_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [FUNC_W-1:0]        func,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          done,
  output logic                          ok,
  output logic [CNT_W-1:0]              count,
  output logic signed [DATA_W-1:0]      element,
  output logic [IDX_W-1:0]              element_index,
  output logic                          element_valid,
  output logic                          last
);

  iiea_cmd_t cmd;
  iiea_sts_t sts;

  iiea_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  iiea_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .position      (position),
    .value         (value),
    .sts           (sts),
    .done          (done),
    .ok            (ok),
    .count         (count),
    .element       (element),
    .element_index (element_index),
    .element_valid (element_valid),
    .last          (last)
  );

endmodule

`default_nettype wire

// File: hdl/iiea_ctrl.sv
// controller state machine for the indexed insert/erase array
// depends on iiea_pkg
`timescale 1ns / 1ps
`default_nettype none

module iiea_ctrl import iiea_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [FUNC_W-1:0] func,
  input  wire iiea_sts_t         sts,
  output iiea_cmd_t              cmd,
  output logic                   busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.exec      = 1'b0;
    cmd.dump_step = 1'b0;
    busy          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          // a dump of a non-empty list walks the chain, all else is one result
          if (func == FUNC_DUMP && !sts.count_zero) begin
            state_next = ST_DUMP;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        busy          = 1'b1;
        cmd.dump_step = 1'b1;
        if (sts.dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/iiea_dpath.sv
// entry chain, length count, readout pointer and result registers
// depends on iiea_pkg
`timescale 1ns / 1ps
`default_nettype none

module iiea_dpath import iiea_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire iiea_cmd_t                cmd,
  input  wire logic [FUNC_W-1:0]        func,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output iiea_sts_t                     sts,
  output logic                          done,
  output logic                          ok,
  output logic [CNT_W-1:0]              count,
  output logic signed [DATA_W-1:0]      element,
  output logic [IDX_W-1:0]              element_index,
  output logic                          element_valid,
  output logic                          last
);

  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic signed [DATA_W-1:0] entry_below [CAPACITY];
  logic signed [DATA_W-1:0] entry_above [CAPACITY];
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         entry_count_next;
  logic [PTR_W-1:0]         ptr;
  logic [CNT_W-1:0]         pos_ext;
  logic                     ins_ok;
  logic                     ers_ok;
  logic                     do_ins;
  logic                     do_ers;
  logic                     op_ok;

  assign pos_ext = CNT_W'(position);
  assign ins_ok  = (entry_count < CAP_CNT) && (pos_ext <= entry_count);
  assign ers_ok  = (entry_count != '0) && (pos_ext < entry_count);
  assign do_ins  = cmd.exec && (func == FUNC_INSERT) && ins_ok;
  assign do_ers  = cmd.exec && (func == FUNC_ERASE) && ers_ok;

  assign sts.count_zero = (entry_count == '0);
  assign sts.dump_last  = ((CNT_W'(ptr) + CNT_W'(1)) == entry_count);

  always_comb begin
    op_ok            = 1'b0;
    entry_count_next = entry_count;
    unique case (func)
      FUNC_INSERT: begin
        op_ok = ins_ok;
        if (ins_ok) begin
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      FUNC_ERASE: begin
        op_ok = ers_ok;
        if (ers_ok) begin
          entry_count_next = entry_count - CNT_W'(1);
        end
      end
      FUNC_DUMP: begin
        // only an empty list reaches here
        op_ok = 1'b1;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // neighbor taps of the chain, ends tied off
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign entry_below[g] = value;
    end else begin : g_mid
      assign entry_below[g] = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign entry_above[g] = entry[g];
    end else begin : g_inner
      assign entry_above[g] = entry[g+1];
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (CNT_W'(g) == pos_ext) begin
          entry[g] <= value;
        end else if (CNT_W'(g) > pos_ext) begin
          entry[g] <= entry_below[g];
        end
      end else if (do_ers) begin
        if (CNT_W'(g) >= pos_ext) begin
          entry[g] <= entry_above[g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      ptr         <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.exec || cmd.dump_step;
      if (cmd.exec) begin
        entry_count <= entry_count_next;
      end
      if (cmd.dump_step) begin
        ptr <= sts.dump_last ? '0 : ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_step) begin
      ok            <= 1'b1;
      count         <= entry_count;
      element       <= entry[ptr];
      element_index <= IDX_W'(ptr);
      element_valid <= 1'b1;
      last          <= sts.dump_last;
    end else if (cmd.exec) begin
      ok            <= op_ok;
      count         <= entry_count_next;
      element       <= '0;
      element_index <= '0;
      element_valid <= 1'b0;
      last          <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/iiea_checker.sv
// port-level checks for the indexed insert/erase array, with its bind
// depends on iiea_pkg and indexed_insert_erase_array
`timescale 1ns / 1ps
`default_nettype none

module iiea_checker import iiea_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [FUNC_W-1:0]        func,
  input wire logic                     done,
  input wire logic                     ok,
  input wire logic [CNT_W-1:0]         count,
  input wire logic                     element_valid,
  input wire logic                     last
);

  // list never grows past its storage
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CAP_CNT))
    else $error("count above capacity");

  // a result without an entry always closes its item
  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    (done && !element_valid) |-> last)
    else $error("non-entry result not marked last");

  // dump entries come back to back until the last one
  a_dump_run: assert property (@(posedge clk) disable iff (rst)
    (done && element_valid && !last) |=> (done && element_valid && ok))
    else $error("dump run broken");

  // insert or erase answers in the next cycle with a single result
  a_op_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_INSERT || func == FUNC_ERASE))
      |=> (done && last && !element_valid))
    else $error("insert or erase result missing");

  // a dump either starts walking or answers for an empty list
  a_dump_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_DUMP) |=> (busy || (done && ok && last)))
    else $error("dump did not start");

endmodule

bind indexed_insert_erase_array iiea_checker u_iiea_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .func          (func),
  .done          (done),
  .ok            (ok),
  .count         (count),
  .element_valid (element_valid),
  .last          (last)
);

`default_nettype wire

// File: tb/indexed_insert_erase_array_tb.sv
// testbench for the indexed insert/erase array: directed table, then random items
// with burst/gap pacing; results checked against fixed rows or a list predictor
// depends on iiea_pkg and indexed_insert_erase_array
`timescale 1ns / 1ps

module indexed_insert_erase_array_tb;
  import iiea_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 445;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_LEN   = 48;

  typedef struct packed {
    logic              ok;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] element;
    logic [IDX_W-1:0]  element_index;
    logic              element_valid;
    logic              last;
  } list_result_t;

  // one stimulus row; typed rows carry a fixed single-result expectation
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              typed;
    logic              ok;
    logic [CNT_W-1:0]  cnt;
  } op_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [FUNC_W-1:0]        func = FUNC_INSERT;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic                     ok;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] element;
  logic [IDX_W-1:0]         element_index;
  logic                     element_valid;
  logic                     last;

  // predictor state
  logic [DATA_W-1:0] list_mem [CAPACITY];
  int                list_len = 0;

  list_result_t op_results[$];
  list_result_t pending_results[$];
  op_row_t      dir_rows[$];
  int           errors = 0;
  int           cycles = 0;

  indexed_insert_erase_array dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .position      (position),
    .value         (value),
    .done          (done),
    .ok            (ok),
    .count         (count),
    .element       (element),
    .element_index (element_index),
    .element_valid (element_valid),
    .last          (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic op_row_t row(logic [FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                                  logic [DATA_W-1:0] val);
    op_row_t r;
    r = '0;
    r.op = op;
    r.pos = pos;
    r.val = val;
    return r;
  endfunction

  function automatic op_row_t chk_row(logic [FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                                      logic [DATA_W-1:0] val, logic exp_ok,
                                      logic [CNT_W-1:0] exp_cnt);
    op_row_t r;
    r = row(op, pos, val);
    r.typed = 1'b1;
    r.ok = exp_ok;
    r.cnt = exp_cnt;
    return r;
  endfunction

  // list behavior: updates the held list and fills op_results
  function automatic void apply_list_op(logic [FUNC_W-1:0] op, logic [POS_W-1:0] pos,
                                        logic [DATA_W-1:0] val);
    list_result_t r;
    int p;
    int i;
    op_results.delete();
    p = int'(pos);
    r = '0;
    r.last = 1'b1;
    case (op)
      FUNC_INSERT: begin
        if (list_len < CAPACITY && p <= list_len) begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      FUNC_ERASE: begin
        if (list_len > 0 && p < list_len) begin
          for (i = p + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
          r.ok = 1'b1;
        end
      end
      FUNC_DUMP: begin
        r.ok = 1'b1;
        if (list_len > 0) begin
          for (i = 0; i < list_len; i++) begin
            r.count = CNT_W'(list_len);
            r.element = list_mem[i];
            r.element_index = IDX_W'(i);
            r.element_valid = 1'b1;
            r.last = (i + 1 == list_len);
            op_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(list_len);
    op_results.push_back(r);
  endfunction

  // present one item and hold it until it is taken, then record what it should give
  task automatic run_row(op_row_t r);
    list_result_t fixed;
    start <= 1'b1;
    func <= r.op;
    position <= r.pos;
    value <= r.val;
    do @(posedge clk); while (busy);
    apply_list_op(r.op, r.pos, r.val);
    if (r.typed) begin
      fixed = '0;
      fixed.ok = r.ok;
      fixed.count = r.cnt;
      fixed.last = 1'b1;
      pending_results.push_back(fixed);
    end else begin
      foreach (op_results[k]) pending_results.push_back(op_results[k]);
    end
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    func <= FUNC_W'($urandom);
    position <= POS_W'($urandom);
    value <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic op_row_t random_row(bit grow);
    op_row_t r;
    int roll;
    int ins_weight;
    r = row(FUNC_INSERT, POS_W'($urandom), $urandom);
    roll = $urandom_range(99);
    ins_weight = grow ? 60 : 25;
    if (roll < 5) r.op = FUNC_UNUSED;
    else if (roll < 13) r.op = FUNC_DUMP;
    else if (roll < 13 + ins_weight) r.op = FUNC_INSERT;
    else r.op = FUNC_ERASE;
    // mostly legal positions, the rest anywhere in the field
    if ($urandom_range(99) < 85) begin
      if (r.op == FUNC_INSERT) r.pos = POS_W'($urandom_range(list_len));
      else if (list_len > 0) r.pos = POS_W'($urandom_range(list_len - 1));
      else r.pos = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst && done) begin
      got = {ok, count, element, element_index, element_valid, last};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got ok=%0d count=%0d element=%0d",
                 $time, got.ok, got.count, $signed(got.element));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected ok=%0d count=%0d element=%0d idx=%0d",
                   $time, want.ok, want.count, $signed(want.element), want.element_index,
                   " valid=%0d last=%0d", want.element_valid, want.last);
          $display("%0t:           actual ok=%0d count=%0d element=%0d idx=%0d",
                   $time, got.ok, got.count, $signed(got.element), got.element_index,
                   " valid=%0d last=%0d", got.element_valid, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int burst_left;
    bit grow;
    dir_rows = '{
      chk_row(FUNC_ERASE,  6'd0,  32'h0000_0000, 1'b0, 7'd0),
      chk_row(FUNC_DUMP,   6'd0,  32'h0000_0000, 1'b1, 7'd0),
      chk_row(FUNC_UNUSED, 6'd0,  32'h1234_5678, 1'b0, 7'd0),
      chk_row(FUNC_INSERT, 6'd1,  32'h0000_0001, 1'b0, 7'd0),
      chk_row(FUNC_INSERT, 6'd0,  32'h7fff_ffff, 1'b1, 7'd1),
      chk_row(FUNC_INSERT, 6'd0,  32'h8000_0000, 1'b1, 7'd2),
      chk_row(FUNC_INSERT, 6'd2,  32'hffff_ffff, 1'b1, 7'd3),
      chk_row(FUNC_INSERT, 6'd63, 32'h0000_0000, 1'b0, 7'd3),
      row(FUNC_DUMP, 6'd63, 32'hdead_beef),
      chk_row(FUNC_ERASE,  6'd3,  32'h0000_0000, 1'b0, 7'd3),
      // fill to capacity at scattered positions
      row(FUNC_INSERT, 6'd3,  32'h0000_0001),
      row(FUNC_INSERT, 6'd0,  32'h5555_5555),
      row(FUNC_INSERT, 6'd2,  32'haaaa_aaaa),
      row(FUNC_INSERT, 6'd6,  32'h0000_0000),
      row(FUNC_INSERT, 6'd1,  32'h0f0f_0f0f),
      row(FUNC_INSERT, 6'd8,  32'hf0f0_f0f0),
      row(FUNC_INSERT, 6'd4,  32'h8000_0001),
      row(FUNC_INSERT, 6'd10, 32'h7fff_fffe),
      row(FUNC_INSERT, 6'd5,  32'h0000_ffff),
      row(FUNC_INSERT, 6'd12, 32'hffff_0000),
      row(FUNC_INSERT, 6'd7,  32'h3333_cccc),
      row(FUNC_INSERT, 6'd14, 32'hcccc_3333),
      row(FUNC_INSERT, 6'd15, 32'h0123_4567),
      chk_row(FUNC_INSERT, 6'd0,  32'h0000_0002, 1'b0, 7'd16),
      row(FUNC_DUMP, 6'd0, 32'h0000_0000),
      chk_row(FUNC_ERASE,  6'd15, 32'h0000_0000, 1'b1, 7'd15),
      chk_row(FUNC_UNUSED, 6'd63, 32'hffff_ffff, 1'b0, 7'd15)
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) run_row(dir_rows[k]);

    burst_left = 0;
    grow = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) grow = ~grow;
      if (n == RAND_ITEMS / 2) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 7));
      end
      burst_left--;
      run_row(random_row(grow));
    end

    drain_results();
    // dump results pass the state and result registers; leave room for strays
    repeat (CAPACITY + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
